@@ rtl/core/mep_pkg.sv @@
package mep_pkg;

    localparam int FRAC_BITS = 28;
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ZOOM_SCALE = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAN_REAL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_PAN_IMAG   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHIFT_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y    = 3'd4;

    localparam logic [30:0]        ZOOM_RESET = 31'd2684355;
    localparam logic signed [31:0] PANR_RESET = -32'sd268435;
    localparam logic signed [31:0] PANI_RESET = 32'sd0;

    typedef struct packed {
        logic [30:0]        zoom_scale;
        logic signed [31:0] pan_real;
        logic signed [31:0] pan_imag;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
    } cfg_t;

    // one pixel between iteration stages
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [CNT_W-1:0]   cnt;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic [8:0]         px;
        logic [8:0]         py;
    } iter_pkt_t;

    // products, between the two halves of an iteration
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [CNT_W-1:0]   cnt;
        logic signed [63:0] rr;
        logic signed [63:0] ii;
        logic signed [63:0] ri;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic [8:0]         px;
        logic [8:0]         py;
    } prod_pkt_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -65'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // x mod 255 by folding bytes (2^8 == 1 mod 255)
    function automatic logic [7:0] mod255(input logic [16:0] x);
        logic [8:0] s;
        logic [8:0] t;
        s = {1'b0, x[7:0]} + {1'b0, x[15:8]} + {8'd0, x[16]};
        t = {1'b0, s[7:0]} + {8'd0, s[8]};
        if (t >= 9'd255)
            t = t - 9'd255;
        return t[7:0];
    endfunction

endpackage

@@ rtl/core/mandelbrot_escape_pixel_core.sv @@
// Mandelbrot escape-time pixel engine.
// Input channel (in_valid/in_ready) takes one beat per pixel: pixel_x, pixel_y.
// Output channel (out_valid/out_ready) returns one beat per pixel: iter_count
// and the red/green/blue color, in input order.
// Config channel (cfg_valid/cfg_ready) writes cfg_data into register cfg_index:
// 0 zoom_scale, 1 pan_real, 2 pan_imag, 3 center_shift_x, 4 center_shift_y;
// other indexes are dropped. cfg_ready is always high; write only while idle.
// Pipeline: 2 mapping stages, 2 stages per iteration (multiply, then
// add/escape test/saturate) for MAX_ITER iterations, 2 color stages.
// Throughput is one pixel per cycle while the pipeline is not stalled.
// Escaped pixels ride on through the later iteration stages with count frozen.
// The whole pipeline advances together: when out_valid is high and out_ready
// low, every stage holds and in_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the default view registers.
module mandelbrot_escape_pixel_core #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512,
    parameter int MAX_ITER     = 56
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [8:0]               pixel_x,
    input  logic [8:0]               pixel_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [5:0]               iter_count,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [mep_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]              cfg_data
);
    import mep_pkg::*;

    cfg_t      cfg_reg;
    logic      advance;
    iter_pkt_t chain [0:MAX_ITER];

    // single stall signal for the whole pipe
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zoom_scale <= ZOOM_RESET;
            cfg_reg.pan_real   <= PANR_RESET;
            cfg_reg.pan_imag   <= PANI_RESET;
            cfg_reg.shift_x    <= -16'(IMAGE_WIDTH);
            cfg_reg.shift_y    <= -16'(IMAGE_HEIGHT);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ZOOM_SCALE: cfg_reg.zoom_scale <= cfg_data[30:0];
                REG_PAN_REAL:   cfg_reg.pan_real   <= cfg_data;
                REG_PAN_IMAG:   cfg_reg.pan_imag   <= cfg_data;
                REG_SHIFT_X:    cfg_reg.shift_x    <= cfg_data[15:0];
                REG_SHIFT_Y:    cfg_reg.shift_y    <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    mep_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (in_valid),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .cfg      (cfg_reg),
        .pkt_out  (chain[0])
    );

    for (genvar g = 0; g < MAX_ITER; g++)
    begin : g_iter
        mep_iter u_iter (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .pkt_in  (chain[g]),
            .pkt_out (chain[g+1])
        );
    end

    mep_color u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .pkt_in     (chain[MAX_ITER]),
        .out_valid  (out_valid),
        .iter_count (iter_count),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

@@ rtl/core/mep_map.sv @@
module mep_map
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [8:0]        pixel_x,
    input  logic [8:0]        pixel_y,
    input  mep_pkg::cfg_t     cfg,
    output mep_pkg::iter_pkt_t pkt_out
);
    import mep_pkg::*;

    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [31:0] zoom_s;
    logic signed [49:0] prod_x_reg;
    logic signed [49:0] prod_y_reg;
    logic [8:0]         px_reg;
    logic [8:0]         py_reg;
    logic               v1_reg;
    logic signed [64:0] sum_x;
    logic signed [64:0] sum_y;
    iter_pkt_t          out_reg;

    assign pos_x  = $signed({8'd0, pixel_x, 1'b0}) + 18'(cfg.shift_x);
    assign pos_y  = $signed({8'd0, pixel_y, 1'b0}) + 18'(cfg.shift_y);
    assign zoom_s = $signed({1'b0, cfg.zoom_scale});

    // floor halving, then pan
    assign sum_x = 65'(prod_x_reg >>> 1) + 65'(cfg.pan_real);
    assign sum_y = 65'(prod_y_reg >>> 1) + 65'(cfg.pan_imag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            prod_x_reg <= '0;
            prod_y_reg <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            out_reg    <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            out_reg.valid <= v1_reg;
            prod_x_reg    <= 50'(pos_x) * 50'(zoom_s);
            prod_y_reg    <= 50'(pos_y) * 50'(zoom_s);
            px_reg        <= pixel_x;
            py_reg        <= pixel_y;
            out_reg.done  <= 1'b0;
            out_reg.cnt   <= '0;
            out_reg.cr    <= sat32(sum_x);
            out_reg.ci    <= sat32(sum_y);
            out_reg.zr    <= sat32(sum_x);
            out_reg.zi    <= sat32(sum_y);
            out_reg.px    <= px_reg;
            out_reg.py    <= py_reg;
        end
    end

    assign pkt_out = out_reg;

endmodule

@@ rtl/core/mep_iter.sv @@
module mep_iter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  mep_pkg::iter_pkt_t pkt_in,
    output mep_pkg::iter_pkt_t pkt_out
);
    import mep_pkg::*;

    prod_pkt_t          mid_reg;
    iter_pkt_t          out_reg;
    logic [63:0]        mag;
    logic               esc;
    logic signed [64:0] new_r;
    logic signed [64:0] new_i;

    // |z|^2 >= 4 in Q(2*FRAC_BITS)
    assign mag   = 64'(mid_reg.rr) + 64'(mid_reg.ii);
    assign esc   = |mag[63:2*FRAC_BITS+2];
    assign new_r = 65'((mid_reg.rr - mid_reg.ii) >>> FRAC_BITS) + 65'(mid_reg.cr);
    assign new_i = 65'(mid_reg.ri >>> (FRAC_BITS - 1)) + 65'(mid_reg.ci);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else if (en)
        begin
            mid_reg.valid <= pkt_in.valid;
            mid_reg.done  <= pkt_in.done;
            mid_reg.cnt   <= pkt_in.cnt;
            mid_reg.rr    <= 64'(pkt_in.zr) * 64'(pkt_in.zr);
            mid_reg.ii    <= 64'(pkt_in.zi) * 64'(pkt_in.zi);
            mid_reg.ri    <= 64'(pkt_in.zr) * 64'(pkt_in.zi);
            mid_reg.cr    <= pkt_in.cr;
            mid_reg.ci    <= pkt_in.ci;
            mid_reg.px    <= pkt_in.px;
            mid_reg.py    <= pkt_in.py;

            out_reg.valid <= mid_reg.valid;
            out_reg.cr    <= mid_reg.cr;
            out_reg.ci    <= mid_reg.ci;
            out_reg.px    <= mid_reg.px;
            out_reg.py    <= mid_reg.py;
            if (mid_reg.done || esc)
            begin
                out_reg.done <= 1'b1;
                out_reg.cnt  <= mid_reg.cnt;
                out_reg.zr   <= '0;
                out_reg.zi   <= '0;
            end
            else
            begin
                out_reg.done <= 1'b0;
                out_reg.cnt  <= mid_reg.cnt + 1'b1;
                out_reg.zr   <= sat32(new_r);
                out_reg.zi   <= sat32(new_i);
            end
        end
    end

    assign pkt_out = out_reg;

endmodule

@@ rtl/core/mep_color.sv @@
module mep_color
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  mep_pkg::iter_pkt_t         pkt_in,
    output logic                       out_valid,
    output logic [5:0]                 iter_count,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue
);
    import mep_pkg::*;

    logic             v1_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [16:0]      gx_reg;
    logic [16:0]      by_reg;
    logic             valid_reg;
    logic [5:0]       count_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= pkt_in.valid;
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg   <= pkt_in.cnt;
            gx_reg    <= 17'(pkt_in.cnt) * 17'(pkt_in.px);
            by_reg    <= 17'(pkt_in.cnt) * 17'(pkt_in.py);
            count_reg <= cnt_reg[5:0];
            red_reg   <= {cnt_reg[4:0], 3'b000};
            green_reg <= mod255(gx_reg);
            blue_reg  <= mod255(by_reg);
        end
    end

    assign out_valid  = valid_reg;
    assign iter_count = count_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

endmodule

@@ rtl/core/mep_checker.sv @@
module mep_checker #(
    parameter int MAX_ITER = 56
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] iter_count,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    // stalled result beat holds valid, iter_count and green
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iter_count) && $stable(green))
        else $error("result beat changed while stalled");

    a_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red == {iter_count[4:0], 3'b000})
        else $error("red does not follow count");

    a_mod: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> green != 8'hff && blue != 8'hff)
        else $error("color not reduced mod 255");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(iter_count) <= MAX_ITER)
        else $error("count above limit");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input not tied to pipeline advance");

endmodule

bind mandelbrot_escape_pixel_core mep_checker #(.MAX_ITER(MAX_ITER)) u_mep_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iter_count (iter_count),
    .red        (red),
    .green      (green),
    .blue       (blue)
);
